[rtl/vn3_pkg.sv]
// Shared constants for the 3D vector normalizer.
package vn3_pkg;
   localparam int COMP_W  = 32;   // component width
   localparam int FRAC_W  = 30;   // Q1.30 fraction bits
   localparam int NBITS   = FRAC_W + 1;  // result magnitude bits, one per stage
   localparam int SQ_W    = 2 * COMP_W;  // square / sum width
   localparam int ACC_W   = 130;  // signed width of the running products
   localparam int NCOMP   = 3;
endpackage

[rtl/vector_normalize_3d.sv]
// Top level: pipelined three-component vector normalizer to signed Q1.30.
//
// Usage:
//   A word (req_x_in, req_y_in, req_z_in) is taken at a rising edge where
//   start is high and busy is low. busy is always low: a new word may be
//   started in every cycle.
//   Each result word appears on rsp_x_unit, rsp_y_unit, rsp_z_unit and
//   rsp_zero_length for exactly one cycle, marked by rsp_valid.
//   Throughput is one word per cycle.
//   The pipeline: magnitude stage, square stage (three 32x32 multipliers),
//   sum stage, then 31 digit stages, one per result bit, each doing wide
//   adds and a compare against the squared component, then a sign stage.
//   Results are rounded to nearest, ties away from zero; a zero vector
//   gives zeros with rsp_zero_length set.
//   Reset clears all valid bits; words in flight are dropped.
//   The receiver cannot stall, so nothing holds the pipeline.
module vector_normalize_3d (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [vn3_pkg::COMP_W-1:0]    req_x_in,
   input  logic signed [vn3_pkg::COMP_W-1:0]    req_y_in,
   input  logic signed [vn3_pkg::COMP_W-1:0]    req_z_in,
   output logic                                 rsp_valid,
   output logic signed [vn3_pkg::COMP_W-1:0]    rsp_x_unit,
   output logic signed [vn3_pkg::COMP_W-1:0]    rsp_y_unit,
   output logic signed [vn3_pkg::COMP_W-1:0]    rsp_z_unit,
   output logic                                 rsp_zero_length
);
   import vn3_pkg::*;

   // stage 0: magnitudes and signs
   logic [COMP_W-1:0] mag_ff [NCOMP];
   logic              neg0_ff [NCOMP];
   logic              v0_ff;
   // stage 1: squares
   logic [SQ_W-1:0]   sq_ff [NCOMP];
   logic              neg1_ff [NCOMP];
   logic              v1_ff;
   // digit stages, index 0 is the sum stage
   logic signed [ACC_W-1:0] a_ff   [NCOMP][NBITS+1];
   logic signed [ACC_W-1:0] b_ff   [NCOMP][NBITS+1];
   logic signed [ACC_W-1:0] rhs_ff [NCOMP][NBITS+1];
   logic [NBITS-1:0]        r_ff   [NCOMP][NBITS+1];
   logic                    ng_ff  [NCOMP][NBITS+1];
   logic signed [ACC_W-1:0] s_ff   [NBITS+1];
   logic                    z_ff   [NBITS+1];
   logic                    v_ff   [NBITS+1];
   // output stage
   logic signed [COMP_W-1:0] out_ff [NCOMP];
   logic                     zo_ff;
   logic                     vo_ff;

   logic signed [COMP_W-1:0] comp_in [NCOMP];
   logic [SQ_W-1:0]          sum_in;

   assign busy = 1'b0;
   assign comp_in[0] = req_x_in;
   assign comp_in[1] = req_y_in;
   assign comp_in[2] = req_z_in;
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v_ff[0] <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
         v_ff[0] <= v1_ff;
         vo_ff <= v_ff[NBITS];
      end
   end

   // front stages: magnitude, square, sum
   always_ff @(posedge clock) begin
      for (int c = 0; c < NCOMP; c++) begin
         neg0_ff[c] <= comp_in[c][COMP_W-1];
         mag_ff[c]  <= comp_in[c][COMP_W-1] ? (COMP_W'(0) - COMP_W'(comp_in[c]))
                                             : COMP_W'(comp_in[c]);
         sq_ff[c]   <= SQ_W'(mag_ff[c]) * SQ_W'(mag_ff[c]);
         neg1_ff[c] <= neg0_ff[c];
         // (2r-1)^2*s and (2r-1)*s with r = 0
         a_ff[c][0]   <= $signed({{(ACC_W-SQ_W){1'b0}}, sum_in});
         b_ff[c][0]   <= -$signed({{(ACC_W-SQ_W){1'b0}}, sum_in});
         rhs_ff[c][0] <= $signed({{(ACC_W-SQ_W){1'b0}}, sq_ff[c]}) <<< (2 * FRAC_W + 2);
         r_ff[c][0]   <= '0;
         ng_ff[c][0]  <= neg1_ff[c];
      end
      s_ff[0] <= $signed({{(ACC_W-SQ_W){1'b0}}, sum_in});
      z_ff[0] <= (sum_in == '0);
   end

   // digit stages: stage k decides result bit NBITS-1-k
   for (genvar k = 0; k < NBITS; k++) begin : g_digit
      localparam int BIT = NBITS - 1 - k;
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else       v_ff[k+1] <= v_ff[k];
      end
      always_ff @(posedge clock) begin
         s_ff[k+1] <= s_ff[k];
         z_ff[k+1] <= z_ff[k];
      end
      for (genvar c = 0; c < NCOMP; c++) begin : g_comp
         logic signed [ACC_W-1:0] t_in;
         logic                    take_in;
         // (2r-1+2^(b+1))^2 * s, built from the running products
         assign t_in = a_ff[c][k] + (b_ff[c][k] <<< (BIT + 2))
                     + (s_ff[k] <<< (2 * BIT + 2));
         // the top bit set means the result is already exactly 1.0
         assign take_in = !r_ff[c][k][NBITS-1] && (t_in <= rhs_ff[c][k]);
         always_ff @(posedge clock) begin
            rhs_ff[c][k+1] <= rhs_ff[c][k];
            ng_ff[c][k+1]  <= ng_ff[c][k];
            if (take_in) begin
               a_ff[c][k+1] <= t_in;
               b_ff[c][k+1] <= b_ff[c][k] + (s_ff[k] <<< (BIT + 1));
               r_ff[c][k+1] <= r_ff[c][k] | (NBITS'(1) << BIT);
            end else begin
               a_ff[c][k+1] <= a_ff[c][k];
               b_ff[c][k+1] <= b_ff[c][k];
               r_ff[c][k+1] <= r_ff[c][k];
            end
         end
      end
   end

   // sign and zero-vector handling
   always_ff @(posedge clock) begin
      for (int c = 0; c < NCOMP; c++) begin
         if (z_ff[NBITS])
            out_ff[c] <= '0;
         else if (ng_ff[c][NBITS])
            out_ff[c] <= -$signed({1'b0, r_ff[c][NBITS]});
         else
            out_ff[c] <= $signed({1'b0, r_ff[c][NBITS]});
      end
      zo_ff <= z_ff[NBITS];
   end

   assign rsp_valid       = vo_ff;
   assign rsp_x_unit      = out_ff[0];
   assign rsp_y_unit      = out_ff[1];
   assign rsp_z_unit      = out_ff[2];
   assign rsp_zero_length = zo_ff;
endmodule
